/* rtl/smx_pkg.sv */
// Shared types, opcodes, status codes and defaults for the stack machine execute unit.
`timescale 1ns / 1ps

package smx_pkg;

    localparam int STACK_DEPTH_DEF = 2048;
    localparam int PC_WIDTH_DEF    = 16;
    localparam int DATA_W          = 64;

    localparam logic [4:0] OP_PUSH     = 5'd0;
    localparam logic [4:0] OP_POP      = 5'd1;
    localparam logic [4:0] OP_DUP      = 5'd2;
    localparam logic [4:0] OP_SWAP     = 5'd3;
    localparam logic [4:0] OP_READ_PTR = 5'd4;
    localparam logic [4:0] OP_DIV      = 5'd8;
    localparam logic [4:0] OP_MUL      = 5'd9;
    localparam logic [4:0] OP_ADD      = 5'd10;
    localparam logic [4:0] OP_SUB      = 5'd11;
    localparam logic [4:0] OP_CMP      = 5'd12;
    localparam logic [4:0] OP_JNE      = 5'd13;
    localparam logic [4:0] OP_JE       = 5'd14;
    localparam logic [4:0] OP_JL       = 5'd15;
    localparam logic [4:0] OP_JG       = 5'd16;
    localparam logic [4:0] OP_JMP      = 5'd17;
    localparam logic [4:0] OP_SYSCALL  = 5'd18;
    localparam logic [4:0] OP_NOP      = 5'd19;
    localparam logic [4:0] OP_LAST     = 5'd31;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_UNDER = 3'd1,
        ST_OVER  = 3'd2,
        ST_DIVZ  = 3'd3,
        ST_UNSUP = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_EXEC,
        S_ITER,
        S_FINISH
    } ctl_state_t;

    typedef struct packed {
        logic [4:0]         command;
        logic signed [63:0] argument;
    } smx_in_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [15:0]        next_pc;
        logic [11:0]        stack_depth;
        logic signed [63:0] top_value;
    } smx_out_t;

    // Controller to datapath.
    typedef struct packed {
        logic load_in;
        logic check;
        logic iter_start;
        logic commit;
        logic load_out;
    } smx_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic err;
        logic use_iter;
        logic iter_done;
        logic out_block;
    } smx_stat_t;

endpackage

/* rtl/smx_iter.sv */
// Iterative 64-bit unit: shift-add multiply and restoring signed divide, one bit per cycle.
`timescale 1ns / 1ps

module smx_iter
    import smx_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              op_mul,
    input  logic [DATA_W-1:0] a,
    input  logic [DATA_W-1:0] b,
    output logic              done,
    output logic [DATA_W-1:0] result
);

    logic              busy_reg;
    logic              done_reg;
    logic [5:0]        cnt_reg;
    logic              mul_reg;
    logic              neg_reg;
    logic [DATA_W:0]   acc_reg;
    logic [DATA_W-1:0] q_reg;
    logic [DATA_W-1:0] m_reg;
    logic [DATA_W-1:0] ua;
    logic [DATA_W-1:0] ub;
    logic [DATA_W:0]   trial;

    assign ua    = a[DATA_W-1] ? (DATA_W'(0) - a) : a;
    assign ub    = b[DATA_W-1] ? (DATA_W'(0) - b) : b;
    assign trial = {acc_reg[DATA_W-1:0], q_reg[DATA_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mul_reg <= op_mul;
            neg_reg <= a[DATA_W-1] ^ b[DATA_W-1];
            acc_reg <= '0;
            q_reg   <= op_mul ? b : ua;
            m_reg   <= op_mul ? a : ub;
        end
        else if (busy_reg)
        begin
            if (mul_reg)
            begin
                if (q_reg[0])
                begin
                    acc_reg <= {1'b0, acc_reg[DATA_W-1:0] + m_reg};
                end
                m_reg <= {m_reg[DATA_W-2:0], 1'b0};
                q_reg <= {1'b0, q_reg[DATA_W-1:1]};
            end
            else
            begin
                if (trial >= {1'b0, m_reg})
                begin
                    acc_reg <= trial - {1'b0, m_reg};
                    q_reg   <= {q_reg[DATA_W-2:0], 1'b1};
                end
                else
                begin
                    acc_reg <= trial;
                    q_reg   <= {q_reg[DATA_W-2:0], 1'b0};
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = mul_reg ? acc_reg[DATA_W-1:0]
                            : (neg_reg ? (DATA_W'(0) - q_reg) : q_reg);

endmodule

/* rtl/smx_ctrl.sv */
// Controller state machine that sequences one instruction through the datapath.
`timescale 1ns / 1ps

module smx_ctrl
    import smx_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  smx_stat_t stat,
    output smx_cmd_t  cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = stat.err ? S_FINISH : S_EXEC;
            end
            S_EXEC:
            begin
                state_next = stat.use_iter ? S_ITER : S_FINISH;
            end
            S_ITER:
            begin
                if (stat.iter_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!stat.out_block)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                req_stall   = 1'b0;
                cmd.load_in = req_valid;
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
            end
            S_EXEC:
            begin
                cmd.iter_start = stat.use_iter;
                cmd.commit     = !stat.use_iter;
            end
            S_ITER:
            begin
                cmd.commit = stat.iter_done;
            end
            S_FINISH:
            begin
                cmd.load_out = !stat.out_block;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* rtl/smx_datapath.sv */
// Datapath: pc, stack pointer, top-of-stack register, operand memory and result register.
`timescale 1ns / 1ps

module smx_datapath
    import smx_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int PC_WIDTH    = PC_WIDTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  smx_in_t   req,
    output smx_out_t  rsp,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    input  smx_cmd_t  cmd,
    output smx_stat_t stat
);

    localparam int AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SP_W = $clog2(STACK_DEPTH + 1);

    // The memory holds every entry below the top; the top lives in top_reg.
    logic [DATA_W-1:0] mem [STACK_DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    logic [4:0]          op_reg;
    logic [DATA_W-1:0]   arg_reg;
    logic [SP_W-1:0]     sp_reg;
    logic [PC_WIDTH-1:0] pc_reg;
    logic [DATA_W-1:0]   top_reg;
    status_t             status_reg;
    smx_out_t            out_reg;
    logic                out_valid_reg;

    logic [SP_W-1:0]     sp_m1;
    logic [SP_W-1:0]     sp_m2;
    logic                empty;
    logic                lt2;
    logic                full;
    status_t             status_now;
    logic                use_iter;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [DATA_W-1:0]   alu_res;
    logic                take;
    logic [PC_WIDTH-1:0] pc_inc;
    logic [PC_WIDTH-1:0] pc_rel;
    logic                iter_done;
    logic [DATA_W-1:0]   iter_res;
    logic [DATA_W-1:0]   below;
    logic [31:0]         sp_ext;
    logic [63:0]         pc_ext;

    assign sp_m1 = sp_reg - SP_W'(1);
    assign sp_m2 = sp_reg - SP_W'(2);
    assign empty = (sp_reg == '0);
    assign lt2   = (sp_reg < SP_W'(2));
    assign full  = (sp_reg == SP_W'(STACK_DEPTH));
    assign use_iter = (op_reg == OP_MUL) || (op_reg == OP_DIV);
    assign pc_inc = pc_reg + PC_WIDTH'(1);
    assign pc_rel = pc_reg + arg_reg[PC_WIDTH-1:0];
    assign below  = lt2 ? '0 : rdata_reg;

    always_comb
    begin
        case (op_reg)
            OP_PUSH:
            begin
                status_now = full ? ST_OVER : ST_OK;
            end
            OP_POP, OP_JNE, OP_JE, OP_JL, OP_JG:
            begin
                status_now = empty ? ST_UNDER : ST_OK;
            end
            OP_DUP:
            begin
                status_now = empty ? ST_UNDER : (full ? ST_OVER : ST_OK);
            end
            OP_SWAP, OP_MUL, OP_ADD, OP_SUB, OP_CMP:
            begin
                status_now = lt2 ? ST_UNDER : ST_OK;
            end
            OP_DIV:
            begin
                status_now = lt2 ? ST_UNDER : ((top_reg == '0) ? ST_DIVZ : ST_OK);
            end
            OP_JMP, OP_NOP:
            begin
                status_now = ST_OK;
            end
            default:
            begin
                status_now = ST_UNSUP;
            end
        endcase
    end

    always_comb
    begin
        case (op_reg)
            OP_JNE:  take = (top_reg != '0);
            OP_JE:   take = (top_reg == '0);
            OP_JL:   take = top_reg[DATA_W-1];
            OP_JG:   take = (top_reg != '0) && !top_reg[DATA_W-1];
            OP_JMP:  take = 1'b1;
            default: take = 1'b0;
        endcase
    end

    always_comb
    begin
        case (op_reg)
            OP_ADD:          alu_res = rdata_reg + top_reg;
            OP_SUB, OP_CMP:  alu_res = rdata_reg - top_reg;
            default:         alu_res = iter_res;
        endcase
    end

    // Memory write at commit: push and dup spill the old top, swap replaces the entry below.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = sp_m1[AW-1:0];
        if (cmd.commit)
        begin
            case (op_reg)
                OP_PUSH: wr_en = !empty;
                OP_DUP:  wr_en = 1'b1;
                OP_SWAP:
                begin
                    wr_en   = 1'b1;
                    wr_addr = sp_m2[AW-1:0];
                end
                default: wr_en = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= top_reg;
        end
        if (cmd.check && !lt2)
        begin
            rdata_reg <= mem[sp_m2[AW-1:0]];
        end
    end

    smx_iter u_iter (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.iter_start),
        .op_mul (op_reg == OP_MUL),
        .a      (rdata_reg),
        .b      (top_reg),
        .done   (iter_done),
        .result (iter_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg        <= '0;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                pc_reg <= take ? pc_rel : pc_inc;
                case (op_reg)
                    OP_PUSH, OP_DUP:
                    begin
                        sp_reg <= sp_reg + SP_W'(1);
                    end
                    OP_POP, OP_DIV, OP_MUL, OP_ADD, OP_SUB, OP_CMP,
                    OP_JNE, OP_JE, OP_JL, OP_JG:
                    begin
                        sp_reg <= sp_m1;
                    end
                    default:
                    begin
                        sp_reg <= sp_reg;
                    end
                endcase
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg  <= req.command;
            arg_reg <= req.argument;
        end
        if (cmd.check)
        begin
            status_reg <= status_now;
        end
        if (cmd.commit)
        begin
            case (op_reg)
                OP_PUSH:
                begin
                    top_reg <= arg_reg;
                end
                OP_POP, OP_JNE, OP_JE, OP_JL, OP_JG:
                begin
                    top_reg <= below;
                end
                OP_SWAP:
                begin
                    top_reg <= rdata_reg;
                end
                OP_DIV, OP_MUL, OP_ADD, OP_SUB, OP_CMP:
                begin
                    top_reg <= alu_res;
                end
                default:
                begin
                    top_reg <= top_reg;
                end
            endcase
        end
        if (cmd.load_out)
        begin
            out_reg.status      <= status_reg;
            out_reg.next_pc     <= pc_ext[15:0];
            out_reg.stack_depth <= sp_ext[11:0];
            out_reg.top_value   <= empty ? '0 : top_reg;
        end
    end

    assign sp_ext = 32'(sp_reg);
    assign pc_ext = 64'(pc_reg);

    assign stat.err       = (status_now != ST_OK);
    assign stat.use_iter  = use_iter;
    assign stat.iter_done = iter_done;
    assign stat.out_block = out_valid_reg && rsp_stall;

    assign rsp       = out_reg;
    assign rsp_valid = out_valid_reg;

endmodule

/* rtl/stack_machine_execute_unit.sv */
// Top level of the stack machine execute unit: controller, datapath and handshake ports.
`timescale 1ns / 1ps

// This unit executes one stack-machine instruction per request transaction and returns
// one response transaction carrying the status, the program counter, the stack depth
// and the top of stack after the step. Instructions run one at a time. For push, pop,
// dup, swap, add, sub, cmp, the jumps and nop an accepted request passes through the check
// and execute states to the finish state, which loads the response register; an instruction
// that fails a check goes from the check state straight to the finish state. Mul and div
// wait in the iterate state for the shared iterative unit, which retires one bit per cycle
// over 64 steps. The next request is accepted once the finish state returns to idle. The
// top of stack sits in a register and the entries beneath it sit in a single-port operand
// memory; at most one registered read of the entry below the top is made per instruction.
// A finished response waits in an output register, so the next request is accepted while
// the previous response is still stalled. The memory needs no clearing after reset,
// because only entries below the current depth are ever read.

module stack_machine_execute_unit
    import smx_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int PC_WIDTH    = PC_WIDTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  smx_in_t  req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output smx_out_t rsp
);

    // Command and status buses between the controller and the datapath.
    smx_cmd_t  cmd;
    smx_stat_t stat;

    smx_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    smx_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .PC_WIDTH    (PC_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
